/* rtl/sle_pkg.sv */
`timescale 1ns / 1ps

package sle_pkg;

  // Field widths of the command and result items
  localparam int CMD_W    = 4;
  localparam int POS_W    = 4;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  // Widest list index and count the cells can be told about (depth up to 1024)
  localparam int MAX_IW = 10;
  localparam int MAX_CW = 11;

  // Match bits examined per scan step
  localparam int CHUNK   = 8;
  localparam int CHUNK_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 4'd0,
    CMD_POP_BACK   = 4'd1,
    CMD_PUSH_FRONT = 4'd2,
    CMD_POP_FRONT  = 4'd3,
    CMD_INSERT     = 4'd4,
    CMD_ERASE      = 4'd5,
    CMD_FIND       = 4'd6,
    CMD_REMOVE     = 4'd7,
    CMD_FRONT      = 4'd8,
    CMD_LAST       = 4'd9
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_OPEN,
    CELL_CLOSE
  } cell_op_e;

  // Broadcast to every cell of the row
  typedef struct packed {
    cell_op_e            op;
    logic [MAX_IW-1:0]   at;
    logic [MAX_CW-1:0]   cnt;
  } cell_ctrl_t;

  // Scan unit report back to the controller
  typedef struct packed {
    logic                hit;
    logic                exhausted;
    logic [MAX_IW-1:0]   pos;
  } scan_res_t;

endpackage

/* rtl/sle_cmd_if.sv */
`timescale 1ns / 1ps

interface sle_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [sle_pkg::CMD_W-1:0]           command;
  logic [sle_pkg::POS_W-1:0]           position;
  logic signed [sle_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output command, output position, output value,
                  input ready);
  modport sink   (input valid, input command, input position, input value,
                  output ready);
endinterface

/* rtl/sle_res_if.sv */
`timescale 1ns / 1ps

interface sle_res_if;
  logic                                valid;
  logic                                ready;
  logic [sle_pkg::STATUS_W-1:0]        status;
  logic signed [sle_pkg::VALUE_W-1:0]  read_value;
  logic [sle_pkg::POS_W-1:0]           found_position;
  logic [sle_pkg::COUNT_W-1:0]         item_count;
  logic                                not_empty;

  modport source (output valid, output status, output read_value,
                  output found_position, output item_count, output not_empty,
                  input ready);
  modport sink   (input valid, input status, input read_value,
                  input found_position, input item_count, input not_empty,
                  output ready);
endinterface

/* rtl/sle_cell.sv */
`timescale 1ns / 1ps

module sle_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int IDX        = 0
) (
  input  logic                    clk,
  input  sle_pkg::cell_ctrl_t     ctrl,
  input  logic [DATA_WIDTH-1:0]   wdata,
  input  logic [DATA_WIDTH-1:0]   left,
  input  logic [DATA_WIDTH-1:0]   right,
  input  logic [DATA_WIDTH-1:0]   key,
  output logic [DATA_WIDTH-1:0]   entry,
  output logic                    match,
  output logic [DATA_WIDTH-1:0]   tap
);

  localparam logic [sle_pkg::MAX_IW-1:0] MY_IDX  = sle_pkg::MAX_IW'(IDX);
  localparam logic [sle_pkg::MAX_CW-1:0] MY_NEXT = sle_pkg::MAX_CW'(IDX + 1);

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      sle_pkg::CELL_OPEN: begin
        if (MY_IDX == ctrl.at) begin
          entry <= wdata;
        end else if (MY_IDX > ctrl.at) begin
          entry <= left;
        end
      end
      sle_pkg::CELL_CLOSE: begin
        if (MY_IDX >= ctrl.at) begin
          entry <= right;
        end
      end
      default: begin
      end
    endcase
  end

  // only live entries may match; the tail entry drives its tap
  assign match = (entry == key) && (MY_NEXT <= ctrl.cnt);
  assign tap   = (MY_NEXT == ctrl.cnt) ? entry : '0;

endmodule

/* rtl/sle_scan.sv */
`timescale 1ns / 1ps

module sle_scan #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         load,
  input  logic                         shift,
  input  logic [DEPTH-1:0]             hits,
  input  logic [sle_pkg::MAX_CW-1:0]   cnt,
  output sle_pkg::scan_res_t           res
);

  localparam int VW = ((DEPTH + sle_pkg::CHUNK - 1) / sle_pkg::CHUNK) * sle_pkg::CHUNK;
  localparam int BW = $clog2(VW + 1);

  logic [VW-1:0]                   vec;
  logic [BW-1:0]                   base;
  logic [sle_pkg::CHUNK_W-1:0]     off;
  logic [sle_pkg::MAX_CW:0]        reach;

  always_ff @(posedge clk) begin
    if (load) begin
      vec  <= VW'(hits);
      base <= '0;
    end else if (shift) begin
      vec  <= vec >> sle_pkg::CHUNK;
      base <= base + BW'(sle_pkg::CHUNK);
    end
  end

  // lowest set bit of the current chunk
  always_comb begin
    off = '0;
    for (int j = sle_pkg::CHUNK - 1; j >= 0; j--) begin
      if (vec[j]) begin
        off = sle_pkg::CHUNK_W'(j);
      end
    end
  end

  assign reach         = (sle_pkg::MAX_CW + 1)'(base) + (sle_pkg::MAX_CW + 1)'(sle_pkg::CHUNK);
  assign res.hit       = |vec[sle_pkg::CHUNK-1:0];
  assign res.exhausted = reach >= (sle_pkg::MAX_CW + 1)'(cnt);
  assign res.pos       = sle_pkg::MAX_IW'(base) + sle_pkg::MAX_IW'(off);

endmodule

/* rtl/sequential_list_engine.sv */
`timescale 1ns / 1ps
// Channel | Dir | Payload
// cmd     | in  | command, position, value
// res     | out | status, read_value, found_position, item_count, not_empty
//
// Push, pop, insert, erase, front and last finish in the cycle they are taken:
// one item per cycle while res is not stalled, set by the row of cells shifting in parallel.
// Find and remove hold cmd ready low while they scan: every cell
// compares at once, then the scan unit walks the match bits 8 at a time.
// Reset clears the count and the handshake state and holds cmd ready low;
// entries are not cleared.
// A result held by a stalled res channel blocks the next command.

module sequential_list_engine #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  sle_cmd_if.sink     cmd,
  sle_res_if.source   res
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > sle_pkg::POS_W) ? CW : sle_pkg::POS_W;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t                         state;
  logic                           scan_remove;
  logic [CW-1:0]                  count;

  // combinational decisions for this cycle
  sle_pkg::cell_ctrl_t            ctrl;
  sle_pkg::scan_res_t             scan;
  logic                           accept;
  logic                           start_scan;
  logic                           done;
  logic [CW-1:0]                  count_next;
  logic [sle_pkg::STATUS_W-1:0]   status_next;
  logic [sle_pkg::VALUE_W-1:0]    rd_next;
  logic [sle_pkg::MAX_IW-1:0]     fpos_next;

  // value conversions between the port and the stored width
  logic [63:0]                    in64;
  logic [DATA_WIDTH-1:0]          wdata;
  logic [63:0]                    front64;
  logic [63:0]                    last64;
  logic [DATA_WIDTH-1:0]          last_val;

  logic [EW-1:0]                  pos_x;
  logic [EW-1:0]                  count_x;
  logic                           full;
  logic                           empty;

  logic [DATA_WIDTH-1:0]          entries [DEPTH];
  logic [DATA_WIDTH-1:0]          taps    [DEPTH];
  logic [DEPTH-1:0]               hits;

  assign in64    = 64'(cmd.value);
  assign wdata   = in64[DATA_WIDTH-1:0];
  assign front64 = 64'($signed(entries[0]));
  assign last64  = 64'($signed(last_val));

  assign pos_x   = EW'(cmd.position);
  assign count_x = EW'(count);
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);

  // ---------------------------------------------------------------------
  // Row of cells: each holds one entry and takes its neighbor's on a shift
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = entries[i];
    end else begin : g_mid_l
      assign left_d = entries[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_d = entries[i];
    end else begin : g_mid_r
      assign right_d = entries[i+1];
    end

    sle_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .wdata (wdata),
      .left  (left_d),
      .right (right_d),
      .key   (wdata),
      .entry (entries[i]),
      .match (hits[i]),
      .tap   (taps[i])
    );
  end

  // only the tail cell drives a nonzero tap
  always_comb begin
    last_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      last_val = last_val | taps[i];
    end
  end

  // ---------------------------------------------------------------------
  // First-match scan, loaded when a find or remove is taken
  // ---------------------------------------------------------------------
  sle_scan #(
    .DEPTH (DEPTH)
  ) u_scan (
    .clk   (clk),
    .load  (start_scan),
    .shift (state == S_SCAN),
    .hits  (hits),
    .cnt   (sle_pkg::MAX_CW'(count)),
    .res   (scan)
  );

  // ready waits for an empty output register (or one being emptied now)
  assign cmd.ready = !rst && (state == S_IDLE) && (!res.valid || res.ready);
  assign accept    = cmd.valid && cmd.ready;

  always_comb begin
    ctrl.op     = sle_pkg::CELL_HOLD;
    ctrl.at     = '0;
    ctrl.cnt    = sle_pkg::MAX_CW'(count);
    count_next  = count;
    status_next = sle_pkg::ST_OK;
    rd_next     = '0;
    fpos_next   = '0;
    start_scan  = 1'b0;
    done        = 1'b0;

    if (state == S_IDLE) begin
      if (accept) begin
        done = 1'b1;
        unique case (cmd.command)
          sle_pkg::CMD_PUSH_BACK: begin
            if (full) begin
              status_next = sle_pkg::ST_FULL;
            end else begin
              ctrl.op    = sle_pkg::CELL_OPEN;
              ctrl.at    = sle_pkg::MAX_IW'(count);
              count_next = count + 1'b1;
            end
          end
          sle_pkg::CMD_POP_BACK: begin
            if (empty) begin
              status_next = sle_pkg::ST_EMPTY;
            end else begin
              count_next = count - 1'b1;
            end
          end
          sle_pkg::CMD_PUSH_FRONT: begin
            if (full) begin
              status_next = sle_pkg::ST_FULL;
            end else begin
              ctrl.op    = sle_pkg::CELL_OPEN;
              count_next = count + 1'b1;
            end
          end
          sle_pkg::CMD_POP_FRONT: begin
            if (empty) begin
              status_next = sle_pkg::ST_EMPTY;
            end else begin
              ctrl.op    = sle_pkg::CELL_CLOSE;
              count_next = count - 1'b1;
            end
          end
          sle_pkg::CMD_INSERT: begin
            // position check ranks ahead of the full check
            if (pos_x > count_x) begin
              status_next = sle_pkg::ST_BADPOS;
            end else if (full) begin
              status_next = sle_pkg::ST_FULL;
            end else begin
              ctrl.op    = sle_pkg::CELL_OPEN;
              ctrl.at    = sle_pkg::MAX_IW'(cmd.position);
              count_next = count + 1'b1;
            end
          end
          sle_pkg::CMD_ERASE: begin
            if (pos_x >= count_x) begin
              status_next = sle_pkg::ST_BADPOS;
            end else begin
              ctrl.op    = sle_pkg::CELL_CLOSE;
              ctrl.at    = sle_pkg::MAX_IW'(cmd.position);
              count_next = count - 1'b1;
            end
          end
          sle_pkg::CMD_FIND, sle_pkg::CMD_REMOVE: begin
            start_scan = 1'b1;
            done       = 1'b0;
          end
          sle_pkg::CMD_FRONT: begin
            if (empty) begin
              status_next = sle_pkg::ST_EMPTY;
            end else begin
              rd_next = front64[sle_pkg::VALUE_W-1:0];
            end
          end
          sle_pkg::CMD_LAST: begin
            if (empty) begin
              status_next = sle_pkg::ST_EMPTY;
            end else begin
              rd_next = last64[sle_pkg::VALUE_W-1:0];
            end
          end
          default: begin
            // unused codes: no change, ok
          end
        endcase
      end
    end else begin
      if (scan.hit) begin
        done      = 1'b1;
        fpos_next = scan.pos;
        if (scan_remove) begin
          ctrl.op    = sle_pkg::CELL_CLOSE;
          ctrl.at    = scan.pos;
          count_next = count - 1'b1;
        end
      end else if (scan.exhausted) begin
        done        = 1'b1;
        status_next = sle_pkg::ST_NOTFOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      res.valid   <= 1'b0;
      scan_remove <= 1'b0;
    end else begin
      count <= count_next;

      unique case (state)
        S_IDLE: begin
          if (start_scan) begin
            state       <= S_SCAN;
            scan_remove <= (cmd.command == sle_pkg::CMD_REMOVE);
          end
        end
        S_SCAN: begin
          if (done) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (done) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // result payload, loaded with each finished command
  always_ff @(posedge clk) begin
    if (done) begin
      res.status         <= status_next;
      res.read_value     <= rd_next;
      res.found_position <= sle_pkg::POS_W'(fpos_next);
      res.item_count     <= sle_pkg::COUNT_W'(count_next);
      res.not_empty      <= (count_next != '0);
    end
  end

endmodule
